>>> rtl/dpds_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dpds_pkg
// Shared types and constants of the DSI PLL divider search block.
// ----------------------------------------------------------------------------
package dpds_pkg;

    localparam int unsigned LANE_MIN_KHZ = 31250;
    localparam int unsigned LANE_MAX_KHZ = 500000;
    localparam int unsigned IN_DIV_MAX   = 7;
    localparam int unsigned LOOP_DIV_MIN = 10;
    localparam int unsigned LOOP_DIV_MAX = 125;
    localparam int unsigned OUT_CODE_MAX = 3;
    localparam int unsigned BEST_START   = 1000000;
    localparam int unsigned UI_X4_NUM    = 4000000;
    localparam int unsigned KHZ_PER_MHZ  = 1000;
    localparam int unsigned RATE_NUM     = 12;
    localparam int unsigned RATE_DEN     = 10;
    localparam int unsigned REF_RESET    = 24000;

    localparam int unsigned DVD_W = 28;
    localparam int unsigned DSR_W = 21;
    localparam int unsigned CNT_W = $clog2(DVD_W);

    localparam int unsigned CFG_IDX_W  = 1;
    localparam int unsigned CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_REF_CLOCK = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FAST_PHY  = 1'd1;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_BAD  = 2'd1;
    localparam logic [1:0] ST_NONE = 2'd2;

    typedef struct packed {
        logic [18:0] pixel_clock_khz;
        logic [4:0]  bits_per_pixel;
        logic [2:0]  lane_count;
    } dpds_req_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [2:0]  in_div;
        logic [6:0]  loop_div;
        logic [3:0]  out_div;
        logic [1:0]  out_div_code;
        logic [19:0] achieved_khz;
        logic [7:0]  bit_period_x4;
        logic [9:0]  lane_rate_mbit;
    } dpds_res_t;

    typedef struct packed {
        logic             start;
        logic [DVD_W-1:0] dividend;
        logic [DSR_W-1:0] divisor;
    } dpds_div_in_t;

    typedef struct packed {
        logic             done;
        logic [DVD_W-1:0] quotient;
    } dpds_div_out_t;

endpackage

>>> rtl/dpds_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dpds_div
// Radix-2 restoring divider, one quotient bit per cycle, done pulse at end.
// ----------------------------------------------------------------------------
module dpds_div (
    input  logic                    clk,
    input  logic                    rst_n,
    input  dpds_pkg::dpds_div_in_t  cmd,
    output dpds_pkg::dpds_div_out_t rsp
);
    import dpds_pkg::*;

    logic             run_reg, run_next;
    logic             done_reg, done_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [DSR_W-1:0] rem_reg, rem_next;
    logic [DVD_W-1:0] quo_reg, quo_next;
    logic [DSR_W-1:0] dsr_reg, dsr_next;

    logic [DSR_W:0]   trial;
    logic [DSR_W:0]   diff;
    logic             ge;

    assign trial = {rem_reg, quo_reg[DVD_W-1]};
    assign diff  = trial - {1'b0, dsr_reg};
    assign ge    = trial >= {1'b0, dsr_reg};

    always_comb
    begin
        run_next  = run_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dsr_next  = dsr_reg;
        if (cmd.start)
        begin
            run_next = 1'b1;
            cnt_next = '0;
            rem_next = '0;
            quo_next = cmd.dividend;
            dsr_next = cmd.divisor;
        end
        else if (run_reg)
        begin
            rem_next = ge ? diff[DSR_W-1:0] : trial[DSR_W-1:0];
            quo_next = {quo_reg[DVD_W-2:0], ge};
            cnt_next = cnt_reg + CNT_W'(1);
            if (cnt_reg == CNT_W'(DVD_W - 1))
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dsr_reg <= dsr_next;
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;

endmodule

>>> rtl/dsi_pll_divider_search.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dsi_pll_divider_search
// Lane rate target and PLL divider search over one shared serial divider.
// ----------------------------------------------------------------------------
// divisions: each one runs bit-serially on the shared radix-2 divider;
//   up to 74 divisions per transaction, fewer on an exact match;
//   zero reference or zero lanes is answered in the cycle after start
// throughput: one transaction at a time, busy stays high until the result
// result is shown for one cycle on done; the receiver cannot stall
// reset: control and config registers cleared to defaults, no clearing pass
module dsi_pll_divider_search (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  start,
    output logic                                  busy,
    input  dpds_pkg::dpds_req_t                   req,
    output logic                                  done,
    output dpds_pkg::dpds_res_t                   result,
    input  logic                                  cfg_we,
    input  logic [dpds_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [dpds_pkg::CFG_DATA_W-1:0]       cfg_data
);
    import dpds_pkg::*;

    localparam logic [4:0] S_IDLE    = 5'd0;
    localparam logic [4:0] S_L_WANT1 = 5'd1;
    localparam logic [4:0] S_W_WANT1 = 5'd2;
    localparam logic [4:0] S_L_WANT2 = 5'd3;
    localparam logic [4:0] S_W_WANT2 = 5'd4;
    localparam logic [4:0] S_L_NMIN  = 5'd5;
    localparam logic [4:0] S_W_NMIN  = 5'd6;
    localparam logic [4:0] S_L_NMAX  = 5'd7;
    localparam logic [4:0] S_W_NMAX  = 5'd8;
    localparam logic [4:0] S_L_N     = 5'd9;
    localparam logic [4:0] S_W_N     = 5'd10;
    localparam logic [4:0] S_L_ACH   = 5'd11;
    localparam logic [4:0] S_W_ACH   = 5'd12;
    localparam logic [4:0] S_ADV     = 5'd13;
    localparam logic [4:0] S_FIN     = 5'd14;
    localparam logic [4:0] S_L_UI    = 5'd15;
    localparam logic [4:0] S_W_UI    = 5'd16;
    localparam logic [4:0] S_L_MBPS  = 5'd17;
    localparam logic [4:0] S_W_MBPS  = 5'd18;

    logic [15:0]      ref_clk_reg;
    logic             fast_reg;

    logic [4:0]       state_reg, state_next;
    logic [18:0]      pix_reg, pix_next;
    logic [4:0]       bpp_reg, bpp_next;
    logic [2:0]       lanes_reg, lanes_next;
    logic [19:0]      want_reg, want_next;
    logic [2:0]       i_reg, i_next;
    logic [1:0]       code_reg, code_next;
    logic [6:0]       nmin_reg, nmin_next;
    logic [6:0]       nmax_reg, nmax_next;
    logic [6:0]       n_reg, n_next;
    logic [19:0]      best_reg, best_next;
    logic [2:0]       bi_reg, bi_next;
    logic [6:0]       bn_reg, bn_next;
    logic [1:0]       bc_reg, bc_next;
    logic [20:0]      bach_reg, bach_next;
    logic             found_reg, found_next;
    logic [7:0]       ui_reg, ui_next;
    dpds_res_t        result_reg, result_next;
    logic             done_reg, done_next;

    dpds_div_in_t     div_cmd;
    dpds_div_out_t    div_rsp;

    logic [19:0]      lmin;
    logic [19:0]      lmax;
    logic [19:0]      fmin;
    logic [20:0]      fmax;
    logic [5:0]       io;
    logic [DVD_W-1:0] quo;
    logic [DVD_W-1:0] delta;

    assign lmin = fast_reg ? 20'(LANE_MIN_KHZ * 2) : 20'(LANE_MIN_KHZ);
    assign lmax = fast_reg ? 20'(LANE_MAX_KHZ * 2) : 20'(LANE_MAX_KHZ);
    assign fmin = {lmin[15:0], 4'b0000};
    assign fmax = {lmax, 1'b0};
    assign io   = 6'({3'b000, i_reg} << code_reg);
    assign quo  = div_rsp.quotient;
    assign delta = (quo > DVD_W'(want_reg)) ? (quo - DVD_W'(want_reg))
                                             : (DVD_W'(want_reg) - quo);

    dpds_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (div_cmd),
        .rsp   (div_rsp)
    );

    always_comb
    begin
        div_cmd.start    = 1'b0;
        div_cmd.dividend = '0;
        div_cmd.divisor  = '0;
        case (state_reg)
            S_L_WANT1:
            begin
                div_cmd.start    = 1'b1;
                div_cmd.dividend = DVD_W'(pix_reg) * DVD_W'(bpp_reg);
                div_cmd.divisor  = DSR_W'(lanes_reg);
            end
            S_L_WANT2:
            begin
                div_cmd.start    = 1'b1;
                div_cmd.dividend = quo * DVD_W'(RATE_NUM);
                div_cmd.divisor  = DSR_W'(RATE_DEN);
            end
            S_L_NMIN:
            begin
                div_cmd.start    = 1'b1;
                div_cmd.dividend = DVD_W'(fmin) * DVD_W'(i_reg);
                div_cmd.divisor  = DSR_W'({ref_clk_reg, 1'b0});
            end
            S_L_NMAX:
            begin
                div_cmd.start    = 1'b1;
                div_cmd.dividend = DVD_W'(fmax) * DVD_W'(i_reg);
                div_cmd.divisor  = DSR_W'({ref_clk_reg, 1'b0});
            end
            S_L_N:
            begin
                div_cmd.start    = 1'b1;
                div_cmd.dividend = DVD_W'(io) * DVD_W'(want_reg)
                                 + DVD_W'(ref_clk_reg[15:1]);
                div_cmd.divisor  = DSR_W'(ref_clk_reg);
            end
            S_L_ACH:
            begin
                div_cmd.start    = 1'b1;
                div_cmd.dividend = DVD_W'(ref_clk_reg) * DVD_W'(n_reg)
                                 + DVD_W'(io[5:1]);
                div_cmd.divisor  = DSR_W'(io);
            end
            S_L_UI:
            begin
                div_cmd.start    = 1'b1;
                div_cmd.dividend = DVD_W'(UI_X4_NUM);
                div_cmd.divisor  = bach_reg;
            end
            S_L_MBPS:
            begin
                div_cmd.start    = 1'b1;
                div_cmd.dividend = DVD_W'(bach_reg);
                div_cmd.divisor  = DSR_W'(KHZ_PER_MHZ);
            end
            default:
            begin
                div_cmd.start = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        state_next  = state_reg;
        pix_next    = pix_reg;
        bpp_next    = bpp_reg;
        lanes_next  = lanes_reg;
        want_next   = want_reg;
        i_next      = i_reg;
        code_next   = code_reg;
        nmin_next   = nmin_reg;
        nmax_next   = nmax_reg;
        n_next      = n_reg;
        best_next   = best_reg;
        bi_next     = bi_reg;
        bn_next     = bn_reg;
        bc_next     = bc_reg;
        bach_next   = bach_reg;
        found_next  = found_reg;
        ui_next     = ui_reg;
        result_next = result_reg;
        done_next   = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    pix_next   = req.pixel_clock_khz;
                    bpp_next   = req.bits_per_pixel;
                    lanes_next = req.lane_count;
                    i_next     = 3'd1;
                    code_next  = '0;
                    best_next  = 20'(BEST_START);
                    found_next = 1'b0;
                    if (ref_clk_reg == '0 || req.lane_count == '0)
                    begin
                        result_next        = '0;
                        result_next.status = ST_BAD;
                        done_next          = 1'b1;
                    end
                    else
                    begin
                        state_next = S_L_WANT1;
                    end
                end
            end
            S_L_WANT1: state_next = S_W_WANT1;
            S_W_WANT1:
            begin
                if (div_rsp.done)
                    state_next = S_L_WANT2;
            end
            S_L_WANT2: state_next = S_W_WANT2;
            S_W_WANT2:
            begin
                if (div_rsp.done)
                begin
                    if (quo > DVD_W'(lmax))
                        want_next = lmax;
                    else if (quo < DVD_W'(lmin))
                        want_next = lmin;
                    else
                        want_next = quo[19:0];
                    state_next = S_L_NMIN;
                end
            end
            S_L_NMIN: state_next = S_W_NMIN;
            S_W_NMIN:
            begin
                if (div_rsp.done)
                begin
                    if (quo >= DVD_W'(LOOP_DIV_MAX - 1))
                        state_next = S_FIN;
                    else
                    begin
                        if (quo < DVD_W'(LOOP_DIV_MIN - 1))
                            nmin_next = 7'(LOOP_DIV_MIN);
                        else
                            nmin_next = quo[6:0] + 7'd1;
                        state_next = S_L_NMAX;
                    end
                end
            end
            S_L_NMAX: state_next = S_W_NMAX;
            S_W_NMAX:
            begin
                if (div_rsp.done)
                begin
                    if (quo > DVD_W'(LOOP_DIV_MAX))
                        nmax_next = 7'(LOOP_DIV_MAX);
                    else
                        nmax_next = quo[6:0];
                    code_next  = '0;
                    state_next = S_L_N;
                end
            end
            S_L_N: state_next = S_W_N;
            S_W_N:
            begin
                if (div_rsp.done)
                begin
                    if (quo < DVD_W'(nmin_reg) || quo > DVD_W'(nmax_reg))
                        state_next = S_ADV;
                    else
                    begin
                        n_next     = quo[6:0];
                        state_next = S_L_ACH;
                    end
                end
            end
            S_L_ACH: state_next = S_W_ACH;
            S_W_ACH:
            begin
                if (div_rsp.done)
                begin
                    if (delta < DVD_W'(best_reg))
                    begin
                        best_next  = delta[19:0];
                        bi_next    = i_reg;
                        bn_next    = n_reg;
                        bc_next    = code_reg;
                        bach_next  = quo[20:0];
                        found_next = 1'b1;
                    end
                    if (delta == '0)
                        state_next = S_FIN;
                    else
                        state_next = S_ADV;
                end
            end
            S_ADV:
            begin
                if (code_reg == 2'(OUT_CODE_MAX))
                begin
                    if (i_reg == 3'(IN_DIV_MAX))
                        state_next = S_FIN;
                    else
                    begin
                        i_next     = i_reg + 3'd1;
                        state_next = S_L_NMIN;
                    end
                end
                else
                begin
                    code_next  = code_reg + 2'd1;
                    state_next = S_L_N;
                end
            end
            S_FIN:
            begin
                if (!found_reg)
                begin
                    result_next        = '0;
                    result_next.status = ST_NONE;
                    done_next          = 1'b1;
                    state_next         = S_IDLE;
                end
                else if (bach_reg == '0)
                begin
                    result_next.status         = ST_OK;
                    result_next.in_div         = bi_reg;
                    result_next.loop_div       = bn_reg;
                    result_next.out_div        = 4'(4'd1 << bc_reg);
                    result_next.out_div_code   = bc_reg;
                    result_next.achieved_khz   = '0;
                    result_next.bit_period_x4  = '0;
                    result_next.lane_rate_mbit = '0;
                    done_next                  = 1'b1;
                    state_next                 = S_IDLE;
                end
                else
                begin
                    state_next = S_L_UI;
                end
            end
            S_L_UI: state_next = S_W_UI;
            S_W_UI:
            begin
                if (div_rsp.done)
                begin
                    ui_next    = quo[7:0];
                    state_next = S_L_MBPS;
                end
            end
            S_L_MBPS: state_next = S_W_MBPS;
            S_W_MBPS:
            begin
                if (div_rsp.done)
                begin
                    result_next.status         = ST_OK;
                    result_next.in_div         = bi_reg;
                    result_next.loop_div       = bn_reg;
                    result_next.out_div        = 4'(4'd1 << bc_reg);
                    result_next.out_div_code   = bc_reg;
                    result_next.achieved_khz   = bach_reg[19:0];
                    result_next.bit_period_x4  = ui_reg;
                    result_next.lane_rate_mbit = quo[9:0];
                    done_next                  = 1'b1;
                    state_next                 = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ref_clk_reg <= 16'(REF_RESET);
            fast_reg    <= 1'b0;
            state_reg   <= S_IDLE;
            done_reg    <= 1'b0;
            found_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_REF_CLOCK: ref_clk_reg <= cfg_data;
                    CFG_FAST_PHY:  fast_reg    <= cfg_data[0];
                    default:       fast_reg    <= fast_reg;
                endcase
            end
            state_reg <= state_next;
            done_reg  <= done_next;
            found_reg <= found_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pix_reg    <= pix_next;
        bpp_reg    <= bpp_next;
        lanes_reg  <= lanes_next;
        want_reg   <= want_next;
        i_reg      <= i_next;
        code_reg   <= code_next;
        nmin_reg   <= nmin_next;
        nmax_reg   <= nmax_next;
        n_reg      <= n_next;
        best_reg   <= best_next;
        bi_reg     <= bi_next;
        bn_reg     <= bn_next;
        bc_reg     <= bc_next;
        bach_reg   <= bach_next;
        ui_reg     <= ui_next;
        result_reg <= result_next;
    end

    assign busy   = state_reg != S_IDLE;
    assign done   = done_reg;
    assign result = result_reg;

    a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result strobe while a search is running");

    a_ok_fields: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.status == ST_OK) |->
            (result.in_div != 3'd0 && result.loop_div >= 7'(LOOP_DIV_MIN)
             && result.loop_div <= 7'(LOOP_DIV_MAX)))
        else $error("ok result with dividers out of range");

    a_fail_fields: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.status != ST_OK) |->
            (result.in_div == 3'd0 && result.loop_div == 7'd0
             && result.achieved_khz == 20'd0))
        else $error("failed result with nonzero fields");

    a_bad_fast: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (ref_clk_reg == 16'd0 || req.lane_count == 3'd0)) |=>
            (done && result.status == ST_BAD))
        else $error("bad reference or lane count not answered at once");

endmodule
